@@ sv/c2s_pkg.sv @@
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared widths, angle constants and the arctangent table for the
// cartesian to spherical converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

    // CORDIC datapath: operands carry 24 fraction bits, magnitudes stay below 2^42
    localparam int CORDIC_W     = 44;
    localparam int ANG_W        = 25;
    localparam int CORDIC_STEPS = 23;

    // Angles inside the block in 1/65536 degree
    localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90  * 65536);
    localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180 * 65536);
    localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(360 * 65536);

    // Output angles in 1/256 degree
    localparam logic [16:0] OUT_90  = 17'd23040;
    localparam logic [16:0] OUT_180 = 17'd46080;
    localparam logic [16:0] OUT_270 = 17'd69120;
    localparam logic [16:0] OUT_360 = 17'd92160;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_AZIM_UNDEF = 2'd1,
        ST_ZERO_VEC  = 2'd2
    } t_status;

    // round(atan(2^-i) * 65536 * 180/pi)
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 25'sd2949120;
            1:  v = 25'sd1740967;
            2:  v = 25'sd919879;
            3:  v = 25'sd466945;
            4:  v = 25'sd234379;
            5:  v = 25'sd117304;
            6:  v = 25'sd58666;
            7:  v = 25'sd29335;
            8:  v = 25'sd14668;
            9:  v = 25'sd7334;
            10: v = 25'sd3667;
            11: v = 25'sd1833;
            12: v = 25'sd917;
            13: v = 25'sd458;
            14: v = 25'sd229;
            15: v = 25'sd115;
            16: v = 25'sd57;
            17: v = 25'sd29;
            18: v = 25'sd14;
            19: v = 25'sd7;
            20: v = 25'sd4;
            21: v = 25'sd2;
            22: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/c2s_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// c2s_sqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage,
// with the final remainder and a sideband that travels with each item.
// ----------------------------------------------------------------------------
module c2s_sqrt_pipe
    import c2s_pkg::*;
#(
    parameter int IN_W = 64,
    parameter int SB_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [IN_W-1:0]       i_rad,
    input  logic [SB_W-1:0]       i_sb,
    output logic                  o_vld,
    output logic [IN_W/2-1:0]     o_root,
    output logic [IN_W/2+1:0]     o_rem,
    output logic [SB_W-1:0]       o_sb
);

    localparam int HW = IN_W / 2;
    localparam int RW = HW + 2;

    logic              r_vld  [HW];
    logic [HW-1:0]     r_root [HW];
    logic [RW-1:0]     r_rem  [HW];
    logic [IN_W-1:0]   r_rad  [HW];
    logic [SB_W-1:0]   r_sb   [HW];

    for (genvar k = 0; k < HW; k++) begin : g_stage
        logic            w_vld_in;
        logic [HW-1:0]   w_root_in;
        logic [RW-1:0]   w_rem_in;
        logic [IN_W-1:0] w_rad_in;
        logic [SB_W-1:0] w_sb_in;
        logic [RW-1:0]   w_acc;
        logic [RW-1:0]   w_trial;
        logic            w_ge;

        if (k == 0) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_root_in = '0;
            assign w_rem_in  = '0;
            assign w_rad_in  = i_rad;
            assign w_sb_in   = i_sb;
        end else begin : g_next
            assign w_vld_in  = r_vld[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_rad_in  = r_rad[k-1];
            assign w_sb_in   = r_sb[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign w_acc   = {w_rem_in[RW-3:0], w_rad_in[IN_W-1 -: 2]};
        assign w_trial = {w_root_in, 2'b01};
        assign w_ge    = (w_acc >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? (w_acc - w_trial) : w_acc;
                r_root[k] <= {w_root_in[HW-2:0], w_ge};
                r_rad[k]  <= {w_rad_in[IN_W-3:0], 2'b00};
                r_sb[k]   <= w_sb_in;
            end
        end
    end

    assign o_vld  = r_vld[HW-1];
    assign o_root = r_root[HW-1];
    assign o_rem  = r_rem[HW-1];
    assign o_sb   = r_sb[HW-1];

endmodule

@@ sv/c2s_cordic_pipe.sv @@
// ----------------------------------------------------------------------------
// c2s_cordic_pipe
// Pipelined CORDIC in vectoring mode: atan(b/a) for a >= 0, one
// micro-rotation per stage, frozen once b reaches zero.
// ----------------------------------------------------------------------------
module c2s_cordic_pipe
    import c2s_pkg::*;
#(
    parameter int SB_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic signed [CORDIC_W-1:0]  i_a,
    input  logic signed [CORDIC_W-1:0]  i_b,
    input  logic [SB_W-1:0]             i_sb,
    output logic                        o_vld,
    output logic signed [ANG_W-1:0]     o_ang,
    output logic [SB_W-1:0]             o_sb
);

    logic                       r_vld [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] r_a   [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] r_b   [CORDIC_STEPS];
    logic signed [ANG_W-1:0]    r_acc [CORDIC_STEPS];
    logic [SB_W-1:0]            r_sb  [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
        logic                       w_vld_in;
        logic signed [CORDIC_W-1:0] w_a_in;
        logic signed [CORDIC_W-1:0] w_b_in;
        logic signed [ANG_W-1:0]    w_acc_in;
        logic [SB_W-1:0]            w_sb_in;
        logic signed [CORDIC_W-1:0] w_b_neg;
        logic signed [CORDIC_W-1:0] w_bs;
        logic signed [CORDIC_W-1:0] w_as;
        logic signed [CORDIC_W-1:0] n_a;
        logic signed [CORDIC_W-1:0] n_b;
        logic signed [ANG_W-1:0]    n_acc;

        if (k == 0) begin : g_first
            assign w_vld_in = i_vld;
            assign w_a_in   = i_a;
            assign w_b_in   = i_b;
            assign w_acc_in = '0;
            assign w_sb_in  = i_sb;
        end else begin : g_next
            assign w_vld_in = r_vld[k-1];
            assign w_a_in   = r_a[k-1];
            assign w_b_in   = r_b[k-1];
            assign w_acc_in = r_acc[k-1];
            assign w_sb_in  = r_sb[k-1];
        end

        // shifts truncate toward zero; a never goes negative
        assign w_b_neg = -w_b_in;
        assign w_bs    = w_b_in[CORDIC_W-1] ? -(w_b_neg >>> k) : (w_b_in >>> k);
        assign w_as    = w_a_in >>> k;

        always_comb begin
            if (w_b_in == '0) begin
                n_a   = w_a_in;
                n_b   = w_b_in;
                n_acc = w_acc_in;
            end else if (!w_b_in[CORDIC_W-1]) begin
                n_a   = w_a_in + w_bs;
                n_b   = w_b_in - w_as;
                n_acc = w_acc_in + atan_entry(k);
            end else begin
                n_a   = w_a_in - w_bs;
                n_b   = w_b_in + w_as;
                n_acc = w_acc_in - atan_entry(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]   <= n_a;
                r_b[k]   <= n_b;
                r_acc[k] <= n_acc;
                r_sb[k]  <= w_sb_in;
            end
        end
    end

    assign o_vld = r_vld[CORDIC_STEPS-1];
    assign o_ang = r_acc[CORDIC_STEPS-1];
    assign o_sb  = r_sb[CORDIC_STEPS-1];

endmodule

@@ sv/cartesian_to_spherical_core.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical_core
// Converts a signed (x, y, z) vector, y up, to radius, polar angle from +y
// and azimuth from +z toward +x, angles in 1/256 degree.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+-------------------------------------
//   s       | in  | tvalid / tready   | tdata: coord_x, coord_y, coord_z
//   m       | out | tvalid / tready   | tdata: polar, azimuth, radius
//           |     |                   | tuser: status
//
// One vector per cycle unless the sink stalls. Stages: input register, square
// stage, sum stage, 32 square-root stages, prep stage, 23 CORDIC stages and
// the output register. The 32-bit fractional square root sets the depth.
// Reset (synchronous, active low) clears the valid bits of every stage.
// The whole pipeline advances on one enable; it holds only while a result
// sits in the output register and the sink does not take it.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_core
    import c2s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // coord_x[15:0], coord_y[31:16], coord_z[47:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // polar[15:0], azimuth[32:16], radius[48:33], zero pad
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    // Pipeline enable: advance unless the output holds an untaken transfer
    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // Stage 0: capture the input transfer
    logic               r_s0_vld;
    logic signed [15:0] r_x0, r_y0, r_z0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0 <= i_s_tdata[15:0];
            r_y0 <= i_s_tdata[31:16];
            r_z0 <= i_s_tdata[47:32];
        end
    end

    // Stage 1: squares
    logic               r_s1_vld;
    logic signed [15:0] r_x1, r_y1, r_z1;
    logic [30:0]        r_xx, r_yy, r_zz;
    logic signed [31:0] w_xx, w_yy, w_zz;

    assign w_xx = r_x0 * r_x0;
    assign w_yy = r_y0 * r_y0;
    assign w_zz = r_z0 * r_z0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1 <= r_x0;
            r_y1 <= r_y0;
            r_z1 <= r_z0;
            r_xx <= w_xx[30:0];
            r_yy <= w_yy[30:0];
            r_zz <= w_zz[30:0];
        end
    end

    // Stage 2: horizontal and total squared lengths
    logic               r_s2_vld;
    logic signed [15:0] r_x2, r_y2, r_z2;
    logic [31:0]        r_hsq, r_ssq;
    logic [31:0]        w_hsq;

    assign w_hsq = {1'b0, r_xx} + {1'b0, r_zz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x2  <= r_x1;
            r_y2  <= r_y1;
            r_z2  <= r_z1;
            r_hsq <= w_hsq;
            r_ssq <= w_hsq + {1'b0, r_yy};
        end
    end

    // Square roots: h with 16 fraction bits, and the integer radius.
    // Both run 32 stages so the two results line up.
    logic        w_h_vld;
    logic [31:0] w_h_root;
    logic [47:0] w_h_sb;
    logic [31:0] w_r_root;
    logic [33:0] w_r_rem;
    logic        w_hsq_zero;

    c2s_sqrt_pipe #(
        .IN_W (64),
        .SB_W (48)
    ) u_sqrt_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s2_vld),
        .i_rad   ({r_hsq, 32'd0}),
        .i_sb    ({r_z2, r_y2, r_x2}),
        .o_vld   (w_h_vld),
        .o_root  (w_h_root),
        .o_rem   (),
        .o_sb    (w_h_sb)
    );

    c2s_sqrt_pipe #(
        .IN_W (64),
        .SB_W (1)
    ) u_sqrt_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s2_vld),
        .i_rad   ({32'd0, r_ssq}),
        .i_sb    (r_hsq == '0),
        .o_vld   (),
        .o_root  (w_r_root),
        .o_rem   (w_r_rem),
        .o_sb    (w_hsq_zero)
    );

    // Stage 3: status, rounded radius and CORDIC operands
    logic signed [15:0] w_x3, w_y3, w_z3;
    logic [16:0]        w_ax, w_ay, w_az;
    t_status            w_status;
    logic [31:0]        w_rad_rnd;

    assign w_x3 = w_h_sb[15:0];
    assign w_y3 = w_h_sb[31:16];
    assign w_z3 = w_h_sb[47:32];
    assign w_ax = w_x3[15] ? -{w_x3[15], w_x3} : {w_x3[15], w_x3};
    assign w_ay = w_y3[15] ? -{w_y3[15], w_y3} : {w_y3[15], w_y3};
    assign w_az = w_z3[15] ? -{w_z3[15], w_z3} : {w_z3[15], w_z3};

    // round half up: bump the root when the remainder exceeds it
    assign w_rad_rnd = ({2'b00, w_r_root} < w_r_rem) ? (w_r_root + 32'd1) : w_r_root;

    always_comb begin
        if (w_r_root == '0) begin
            w_status = ST_ZERO_VEC;
        end else if (w_hsq_zero) begin
            w_status = ST_AZIM_UNDEF;
        end else begin
            w_status = ST_OK;
        end
    end

    logic                       r_s3_vld;
    logic signed [CORDIC_W-1:0] r_pa, r_pb, r_aa, r_ab;
    logic [4:0]                 r_flags;   // y_neg, y_pos, x_neg, z_zero, z_neg
    logic [17:0]                r_info;    // status, radius

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= w_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa    <= {3'd0, w_ay, 24'd0};
            r_pb    <= {4'd0, w_h_root, 8'd0};
            r_aa    <= {3'd0, w_az, 24'd0};
            r_ab    <= {3'd0, w_ax, 24'd0};
            r_flags <= {w_y3[15], (!w_y3[15] && w_y3 != '0), w_x3[15],
                        (w_z3 == '0), w_z3[15]};
            r_info  <= {w_status, w_rad_rnd[15:0]};
        end
    end

    // CORDIC lanes: polar from +y, raw azimuth in the first quadrant
    logic                    w_c_vld;
    logic signed [ANG_W-1:0] w_th_p, w_th_a;
    logic [17:0]             w_info;
    logic [4:0]              w_flags;

    c2s_cordic_pipe #(
        .SB_W (18)
    ) u_cordic_polar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s3_vld),
        .i_a     (r_pa),
        .i_b     (r_pb),
        .i_sb    (r_info),
        .o_vld   (w_c_vld),
        .o_ang   (w_th_p),
        .o_sb    (w_info)
    );

    c2s_cordic_pipe #(
        .SB_W (5)
    ) u_cordic_azim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s3_vld),
        .i_a     (r_aa),
        .i_b     (r_ab),
        .i_sb    (r_flags),
        .o_vld   (),
        .o_ang   (w_th_a),
        .o_sb    (w_flags)
    );

    // Final stage: clamp, map to quadrant, round to 1/256 degree
    logic             w_y_neg, w_y_pos, w_x_neg, w_z_zero, w_z_neg;
    t_status          w_st;
    logic [ANG_W-1:0] w_cp, w_ca, w_mp, w_ma, w_rp, w_ra;
    logic [15:0]      n_polar;
    logic [16:0]      n_azim;

    assign {w_y_neg, w_y_pos, w_x_neg, w_z_zero, w_z_neg} = w_flags;
    assign w_st = t_status'(w_info[17:16]);

    // clamp raw angles to [0, 90 degrees]
    assign w_cp = w_th_p[ANG_W-1] ? '0 :
                  ($unsigned(w_th_p) > DEG_90) ? DEG_90 : $unsigned(w_th_p);
    assign w_ca = w_th_a[ANG_W-1] ? '0 :
                  ($unsigned(w_th_a) > DEG_90) ? DEG_90 : $unsigned(w_th_a);

    assign w_mp = w_y_neg ? (DEG_180 - w_cp) : w_cp;

    always_comb begin
        if (!w_z_neg) begin
            w_ma = w_x_neg ? (DEG_360 - w_ca) : w_ca;
        end else begin
            w_ma = w_x_neg ? (DEG_180 + w_ca) : (DEG_180 - w_ca);
        end
    end

    assign w_rp = w_mp + ANG_W'(128);
    assign w_ra = w_ma + ANG_W'(128);

    always_comb begin
        unique case (w_st)
            ST_ZERO_VEC: begin
                n_polar = '0;
                n_azim  = '0;
            end
            ST_AZIM_UNDEF: begin
                n_polar = w_y_pos ? 16'd0 : OUT_180[15:0];
                n_azim  = '0;
            end
            default: begin
                n_polar = (w_rp[ANG_W-1:8] > OUT_180) ? OUT_180[15:0] : w_rp[23:8];
                if (w_z_zero) begin
                    n_azim = w_x_neg ? OUT_270 : OUT_90;
                end else if (w_ra[ANG_W-1:8] >= OUT_360) begin
                    n_azim = '0;   // wrap at 360 degrees
                end else begin
                    n_azim = w_ra[ANG_W-1:8];
                end
            end
        endcase
    end

    logic        r_out_vld;
    logic [15:0] r_polar;
    logic [16:0] r_azim;
    logic [15:0] r_radius;
    logic [1:0]  r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_polar  <= n_polar;
            r_azim   <= n_azim;
            r_radius <= w_info[15:0];
            r_status <= w_info[17:16];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0, r_radius, r_azim, r_polar};
    assign o_m_tuser  = r_status;

endmodule
